### rtl/box_average_filter_top_macros.svh
// Assertion macros for the box average filter
`ifndef BOX_AVERAGE_FILTER_TOP_MACROS_SVH
`define BOX_AVERAGE_FILTER_TOP_MACROS_SVH

// same-cycle implication
`define BAF_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BAF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/baf_pkg.sv
// Shared types and codes for the box average filter
`timescale 1ns / 1ps

package baf_pkg;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  localparam logic [1:0] REG_HALF_WIDTH   = 2'd0;
  localparam logic [1:0] REG_HALF_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd2;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_DRAIN,
    S_DIV_GO,
    S_DIV_WAIT,
    S_LOAD
  } state_t;

  typedef struct packed {
    logic accept;
    logic sum_step;
    logic div_start;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic emit_now;
    logic inside_now;
    logic sum_last;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

### rtl/baf_div.sv
// Three-lane restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module baf_div import baf_pkg::*; #(
  parameter int SW = 16,
  parameter int NW = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [2:0][SW-1:0]   num,
  input  logic [NW-1:0]        den,
  output logic                 done,
  output logic [2:0][SW-1:0]   quo
);

  localparam int CNW = $clog2(SW + 1);

  logic              busy;
  logic [CNW-1:0]    cnt;
  logic [2:0][NW-1:0] rem;
  logic [2:0][NW-1:0] rem_next;
  logic [2:0][SW-1:0] quo_next;
  logic [NW:0]        rem_sh;

  always_comb begin
    rem_next = rem;
    quo_next = quo;
    rem_sh   = '0;
    for (int k = 0; k < 3; k++) begin
      rem_sh = {rem[k], quo[k][SW-1]};
      if (rem_sh >= {1'b0, den}) begin
        rem_next[k] = NW'(rem_sh - {1'b0, den});
        quo_next[k] = {quo[k][SW-2:0], 1'b1};
      end else begin
        rem_next[k] = rem_sh[NW-1:0];
        quo_next[k] = {quo[k][SW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNW'(1);
        if (cnt == CNW'(SW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

endmodule

### rtl/baf_dp.sv
// Datapath: registers, positions, row store, window accumulation, output register
`timescale 1ns / 1ps

module baf_dp import baf_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HALF  = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        kind,
  input  logic [7:0]  chan_blue,
  input  logic [7:0]  chan_green,
  input  logic [7:0]  chan_red,
  input  cmd_t        cmd,
  output status_t     st,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  mean_blue,
  output logic [7:0]  mean_green,
  output logic [7:0]  mean_red,
  output logic        frame_end
);

  localparam int SR    = 2 * MAX_HALF + 1;
  localparam int SLW   = $clog2(SR);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HBW   = $clog2(MAX_HALF + 1);
  localparam int DEPTH = SR * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int DMAX  = MAX_HALF * MAX_WIDTH + MAX_HALF;
  localparam int DW    = $clog2(DMAX + 2);
  localparam int NMAX  = SR * SR;
  localparam int NW    = $clog2(NMAX + 1);
  localparam int SW    = $clog2(NMAX * 255 + 1);

  logic [2:0]  half_width;
  logic [2:0]  half_height;
  logic [10:0] image_width;
  logic [15:0] image_height;

  logic [HBW-1:0] hw;
  logic [HBW-1:0] hh;
  logic [WW-1:0]  w_eff;
  logic [15:0]    h_eff;
  logic [DW-1:0]  delay;
  logic [NW-1:0]  n;

  logic [CW-1:0]  in_col, out_col;
  logic [15:0]    in_row, out_row;
  logic [SLW-1:0] in_slot, out_slot;
  logic [DW-1:0]  pending;

  logic           in_col_end, in_row_end, out_col_end, out_row_end;
  logic [CW-1:0]  in_col_next, out_col_next;
  logic [15:0]    in_row_next, out_row_next;
  logic [SLW-1:0] in_slot_next, out_slot_next;

  logic emit_pix, emit_fl, frame_end_now, pixel_in;

  logic           inside_r, fe_r;
  logic [CW-1:0]  col_base;
  logic [SLW-1:0] slot_y;
  logic [SLW-1:0] slot_start;
  logic [SLW-1:0] xi, yi;
  logic           x_end;

  logic [23:0]    store [DEPTH];
  logic [AW-1:0]  wr_addr, rd_addr;
  logic [23:0]    rd_data;
  logic           rd_valid;
  logic [2:0][SW-1:0] acc;
  logic [2:0][SW-1:0] quo;
  logic           div_done;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      half_width   <= 3'd3;
      half_height  <= 3'd3;
      image_width  <= 11'd640;
      image_height <= 16'd480;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_HALF_WIDTH:   half_width   <= cfg_data[2:0];
        REG_HALF_HEIGHT:  half_height  <= cfg_data[2:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[10:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign hw    = (32'(half_width) > MAX_HALF) ? HBW'(MAX_HALF) : HBW'(half_width);
  assign hh    = (32'(half_height) > MAX_HALF) ? HBW'(MAX_HALF) : HBW'(half_height);
  assign w_eff = (image_width == 11'd0) ? WW'(1) :
                 (32'(image_width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(image_width);
  assign h_eff = (image_height == 16'd0) ? 16'd1 : image_height;
  assign delay = DW'(hh) * DW'(w_eff) + DW'(hw);
  assign n     = NW'({hw, 1'b1}) * NW'({hh, 1'b1});

  // position advance
  assign in_col_end  = ((WW+1)'(in_col) + (WW+1)'(1)) >= (WW+1)'(w_eff);
  assign in_row_end  = (17'(in_row) + 17'd1) >= 17'(h_eff);
  assign out_col_end = ((WW+1)'(out_col) + (WW+1)'(1)) >= (WW+1)'(w_eff);
  assign out_row_end = (17'(out_row) + 17'd1) >= 17'(h_eff);

  always_comb begin
    in_col_next   = in_col_end ? '0 : in_col + CW'(1);
    in_row_next   = in_row;
    in_slot_next  = in_slot;
    if (in_col_end) begin
      in_row_next  = in_row_end ? 16'd0 : in_row + 16'd1;
      in_slot_next = (in_row_end || in_slot == SLW'(SR - 1)) ? '0 : in_slot + SLW'(1);
    end
    out_col_next  = out_col_end ? '0 : out_col + CW'(1);
    out_row_next  = out_row;
    out_slot_next = out_slot;
    if (out_col_end) begin
      out_row_next  = out_row_end ? 16'd0 : out_row + 16'd1;
      out_slot_next = (out_row_end || out_slot == SLW'(SR - 1)) ? '0 : out_slot + SLW'(1);
    end
  end

  assign pixel_in = (kind == KIND_PIXEL);
  assign emit_pix = pixel_in && (pending >= delay);
  assign emit_fl  = (kind == KIND_FLUSH) && (pending != '0) &&
                    (in_col == '0) && (in_row == 16'd0);

  assign st.emit_now   = emit_pix || emit_fl;
  assign st.inside_now = ((WW+1)'(out_col) >= (WW+1)'(hw)) &&
                         (((WW+1)'(out_col) + (WW+1)'(hw)) < (WW+1)'(w_eff)) &&
                         (17'(out_row) >= 17'(hh)) &&
                         ((17'(out_row) + 17'(hh)) < 17'(h_eff));
  assign frame_end_now = (out_row == h_eff - 16'd1) && (WW'(out_col) == w_eff - WW'(1));

  assign slot_start = (out_slot >= SLW'(hh)) ? SLW'(out_slot - SLW'(hh))
                                             : SLW'(out_slot + SLW'(SR) - SLW'(hh));

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col   <= '0;
      in_row   <= '0;
      in_slot  <= '0;
      out_col  <= '0;
      out_row  <= '0;
      out_slot <= '0;
      pending  <= '0;
    end else if (cmd.accept) begin
      if (pixel_in) begin
        in_col  <= in_col_next;
        in_row  <= in_row_next;
        in_slot <= in_slot_next;
      end
      if (st.emit_now) begin
        out_col  <= out_col_next;
        out_row  <= out_row_next;
        out_slot <= out_slot_next;
      end
      if (pixel_in && !st.emit_now) pending <= pending + DW'(1);
      else if (!pixel_in && st.emit_now) pending <= pending - DW'(1);
    end
  end

  // window walk
  assign x_end       = (xi == SLW'({hw, 1'b0}));
  assign st.sum_last = x_end && (yi == SLW'({hh, 1'b0}));

  always_ff @(posedge clk) begin
    if (cmd.accept && st.emit_now) begin
      inside_r <= st.inside_now;
      fe_r     <= frame_end_now;
      col_base <= out_col - CW'(hw);
      slot_y   <= slot_start;
      xi       <= '0;
      yi       <= '0;
    end else if (cmd.sum_step) begin
      if (x_end) begin
        xi     <= '0;
        yi     <= yi + SLW'(1);
        slot_y <= (slot_y == SLW'(SR - 1)) ? '0 : slot_y + SLW'(1);
      end else begin
        xi <= xi + SLW'(1);
      end
    end
  end

  // row store
  assign wr_addr = AW'(AW'(in_slot) * AW'(MAX_WIDTH) + AW'(in_col));
  assign rd_addr = AW'(AW'(slot_y) * AW'(MAX_WIDTH) + AW'(col_base) + AW'(xi));

  always_ff @(posedge clk) begin
    if (cmd.accept && pixel_in) store[wr_addr] <= {chan_red, chan_green, chan_blue};
  end

  always_ff @(posedge clk) begin
    rd_data <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) rd_valid <= 1'b0;
    else     rd_valid <= cmd.sum_step;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && st.emit_now) begin
      acc <= '0;
    end else if (rd_valid) begin
      for (int k = 0; k < 3; k++) acc[k] <= acc[k] + SW'(rd_data[8*k +: 8]);
    end
  end

  baf_div #(.SW(SW), .NW(NW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (acc),
    .den   (n),
    .done  (div_done),
    .quo   (quo)
  );

  assign st.div_done = div_done;
  assign st.out_free = !out_valid || out_ready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mean_blue  <= inside_r ? quo[0][7:0] : 8'd0;
      mean_green <= inside_r ? quo[1][7:0] : 8'd0;
      mean_red   <= inside_r ? quo[2][7:0] : 8'd0;
      frame_end  <= fe_r;
    end
  end

endmodule

### rtl/baf_ctrl.sv
// Controller state machine for the box average filter
`timescale 1ns / 1ps

module baf_ctrl import baf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && st.emit_now) state_next = st.inside_now ? S_SUM : S_LOAD;
      end
      S_SUM:      if (st.sum_last) state_next = S_DRAIN;
      S_DRAIN:    state_next = S_DIV_GO;
      S_DIV_GO:   state_next = S_DIV_WAIT;
      S_DIV_WAIT: if (st.div_done) state_next = S_LOAD;
      S_LOAD:     if (st.out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_SUM:    cmd.sum_step  = 1'b1;
      S_DIV_GO: cmd.div_start = 1'b1;
      S_LOAD:   cmd.load      = st.out_free;
      default: ;
    endcase
  end

endmodule

### rtl/box_average_filter_top.sv
// Top level of the box average filter
//
// Input channel (in_valid/in_ready): kind 0 carries a pixel, kind 1 flushes
// one pending output at the end of a stream. Output channel (out_valid/
// out_ready) carries the window means and frame_end, in raster order, lagging
// the input by half_height rows plus half_width pixels.
// Configuration: cfg_write/cfg_index/cfg_data, taken at once; the user must write
// only while idle, the block itself does not enforce it. A pixel that gives no
// result needs nothing more; a border result goes to the output register as zero;
// an interior result reads its N = (2*hw+1)*(2*hh+1) pixels from the row store one
// pixel a cycle, then is divided by N in the bit-serial divider over S, the sum
// width (16 at defaults). Defaults give a 7x7 window. Results leave through an
// output register, so the next input is taken while a result waits; a stalled
// receiver holds the block only when the next result needs that register.
// Reset restores the register defaults and zeroes the input and output positions
// and the pending count; the row store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module box_average_filter_top import baf_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HALF  = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  chan_blue,
  input  logic [7:0]  chan_green,
  input  logic [7:0]  chan_red,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  mean_blue,
  output logic [7:0]  mean_green,
  output logic [7:0]  mean_red,
  output logic        frame_end
);

  `include "box_average_filter_top_macros.svh"

  cmd_t    cmd;
  status_t st;

  baf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  baf_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HALF(MAX_HALF)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .kind       (kind),
    .chan_blue  (chan_blue),
    .chan_green (chan_green),
    .chan_red   (chan_red),
    .cmd        (cmd),
    .st         (st),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .mean_blue  (mean_blue),
    .mean_green (mean_green),
    .mean_red   (mean_red),
    .frame_end  (frame_end)
  );

  `BAF_ASSERT_IMPLY(a_load_free, cmd.load, !out_valid || out_ready, "load into busy output")
  `BAF_ASSERT_NEXT(a_emit_busy, cmd.accept && st.emit_now, !in_ready, "ready after emitting transfer")
  `BAF_ASSERT_NEXT(a_quiet_ready, cmd.accept && !st.emit_now, in_ready, "stall after silent transfer")

endmodule

### tb/sv/tb_box_average_filter_top.sv
// Self-checking testbench for the box average filter: scoreboard predictor plus driving tasks
`timescale 1ns / 1ps

module tb_box_average_filter_top;
  import baf_pkg::*;

  localparam int MAXW = 1024;
  localparam int MAXH = 7;
  localparam int ROWS = 2 * MAXH + 1;

  typedef struct {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       last;
  } mean_px_t;

  class box_mean_scoreboard;
    logic [23:0] lines [ROWS * MAXW];
    logic [2:0]  hw_reg, hh_reg;
    logic [10:0] w_reg;
    logic [15:0] h_reg;
    int unsigned in_col, in_row, out_col, out_row, backlog;
    int unsigned errors;
    mean_px_t    means_due [$];

    function new();
      foreach (lines[i]) lines[i] = '0;
      hw_reg = 3; hh_reg = 3; w_reg = 640; h_reg = 480;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0; backlog = 0; errors = 0;
    endfunction

    function int unsigned eff_w();
      if (w_reg == 0) return 1;
      return (w_reg > MAXW) ? MAXW : w_reg;
    endfunction

    function int unsigned eff_h();
      return (h_reg == 0) ? 1 : h_reg;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        REG_HALF_WIDTH:   hw_reg = val[2:0];
        REG_HALF_HEIGHT:  hh_reg = val[2:0];
        REG_IMAGE_WIDTH:  w_reg = val[10:0];
        REG_IMAGE_HEIGHT: h_reg = val;
        default: ;
      endcase
    endfunction

    function void step_pos(ref int unsigned col, ref int unsigned row);
      if (col + 1 >= eff_w()) begin
        col = 0;
        row = (row + 1 >= eff_h()) ? 0 : row + 1;
      end else begin
        col = col + 1;
      end
    endfunction

    function void predict_mean();
      int unsigned hw, hh, w, h, c, r, n, sb, sg, sr, y, x;
      logic [23:0] px;
      mean_px_t m;
      hw = hw_reg; hh = hh_reg; w = eff_w(); h = eff_h();
      c = out_col; r = out_row;
      sb = 0; sg = 0; sr = 0;
      if (c >= hw && c + hw < w && r >= hh && r + hh < h) begin
        n = (2 * hw + 1) * (2 * hh + 1);
        for (y = r - hh; y <= r + hh; y++)
          for (x = c - hw; x <= c + hw; x++) begin
            px = lines[(y % ROWS) * MAXW + (x % MAXW)];
            sb += px[7:0]; sg += px[15:8]; sr += px[23:16];
          end
        sb /= n; sg /= n; sr /= n;
      end
      m.blue = sb[7:0]; m.green = sg[7:0]; m.red = sr[7:0];
      m.last = (r == h - 1 && c == w - 1);
      means_due.insert(means_due.size(), m);
      step_pos(out_col, out_row);
      backlog--;
    endfunction

    function void note_transfer(logic k, logic [7:0] b, logic [7:0] g, logic [7:0] r);
      int unsigned lag;
      if (k == KIND_PIXEL) begin
        lag = hh_reg * eff_w() + hw_reg;
        if (in_col < MAXW) lines[(in_row % ROWS) * MAXW + in_col] = {r, g, b};
        step_pos(in_col, in_row);
        backlog++;
        if (backlog > lag) predict_mean();
      end else if (backlog > 0 && in_col == 0 && in_row == 0) begin
        predict_mean();
      end
    endfunction

    function void check_transfer(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic fe);
      mean_px_t m;
      if (means_due.size() == 0) begin
        $display("%0t: unexpected result b=%0d g=%0d r=%0d fe=%0d", $time, b, g, r, fe);
        errors++;
        return;
      end
      m = means_due.pop_front();
      if (b !== m.blue) begin
        $display("%0t: mean_blue exp %0d got %0d", $time, m.blue, b); errors++;
      end
      if (g !== m.green) begin
        $display("%0t: mean_green exp %0d got %0d", $time, m.green, g); errors++;
      end
      if (r !== m.red) begin
        $display("%0t: mean_red exp %0d got %0d", $time, m.red, r); errors++;
      end
      if (fe !== m.last) begin
        $display("%0t: frame_end exp %0d got %0d", $time, m.last, fe); errors++;
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid, in_ready, kind;
  logic [7:0]  chan_blue, chan_green, chan_red;
  logic        out_valid, out_ready;
  logic [7:0]  mean_blue, mean_green, mean_red;
  logic        frame_end;

  box_mean_scoreboard sb = new();
  bit quiet;
  bit long_hold;
  int unsigned rand_items;

  box_average_filter_top i_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind),
    .chan_blue(chan_blue), .chan_green(chan_green), .chan_red(chan_red),
    .out_valid(out_valid), .out_ready(out_ready),
    .mean_blue(mean_blue), .mean_green(mean_green), .mean_red(mean_red),
    .frame_end(frame_end)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("tb_box_average_filter_top: done, errors");
    $finish;
  end

  // receiver: random stalls, one long hold on request
  initial begin
    out_ready = 0;
    forever begin
      if (long_hold) begin
        out_ready <= 0;
        repeat (400) @(posedge clk);
        long_hold = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_ready <= 1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk)
    if (!rst && out_valid && out_ready)
      sb.check_transfer(mean_blue, mean_green, mean_red, frame_end);

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_write <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_write <= 0;
    @(posedge clk);
  endtask

  task automatic setup(int hw, int hh, int w, int h);
    write_reg(REG_HALF_WIDTH, 16'(hw));
    write_reg(REG_HALF_HEIGHT, 16'(hh));
    write_reg(REG_IMAGE_WIDTH, 16'(w));
    write_reg(REG_IMAGE_HEIGHT, 16'(h));
  endtask

  // one transfer in; valid stays high if the next item follows at once
  task automatic push_item(logic k, logic [7:0] b, logic [7:0] g, logic [7:0] r);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1; kind <= k; chan_blue <= b; chan_green <= g; chan_red <= r;
    do @(posedge clk); while (!in_ready);
    sb.note_transfer(k, b, g, r);
  endtask

  task automatic push_pixel();
    push_item(KIND_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic drain_backlog();
    while (sb.backlog > 0)
      push_item(KIND_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic settle();
    in_valid <= 0;
    while (sb.means_due.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  initial begin
    int unsigned hw, hh, w, h, frames, phase;
    rst = 1; cfg_write = 0; cfg_index = '0; cfg_data = '0;
    in_valid = 0; kind = KIND_PIXEL; chan_blue = 0; chan_green = 0; chan_red = 0;
    quiet = 0; long_hold = 0; rand_items = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // small 3x3 window on a 4x3 frame, channel extremes, flush mid-frame and after
    setup(1, 1, 4, 3);
    push_item(KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    push_item(KIND_PIXEL, 8'h00, 8'h00, 8'h00);
    push_item(KIND_FLUSH, 8'hFF, 8'h00, 8'hAA);
    for (int i = 0; i < 10; i++)
      push_item(KIND_PIXEL, (i % 2) ? 8'hFF : 8'h00, 8'hAA, 8'(8'h55 + i));
    drain_backlog();
    push_item(KIND_FLUSH, 8'h00, 8'hFF, 8'h55);
    settle();

    // zero width and height act as a 1x1 frame
    setup(0, 0, 0, 0);
    push_item(KIND_PIXEL, 8'h01, 8'h80, 8'hFE);
    push_item(KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    settle();

    // tallest frame, then cut short mid-frame
    setup(0, 0, 1, 65535);
    for (int i = 0; i < 20; i++) push_pixel();
    settle();
    write_reg(REG_IMAGE_HEIGHT, 21);
    push_pixel();
    settle();

    // width register beyond range saturates, then the row is cut short
    setup(0, 0, 2047, 1);
    for (int i = 0; i < 20; i++) push_pixel();
    settle();
    write_reg(REG_IMAGE_WIDTH, 21);
    push_pixel();
    settle();

    // receiver holds off while every pixel gives a result
    setup(0, 0, 4, 4);
    long_hold = 1;
    for (int i = 0; i < 16; i++) push_pixel();
    settle();

    setup(7, 7, 15, 15);
    for (int i = 0; i < 225; i++) push_pixel();
    drain_backlog();
    settle();

    phase = 0;
    while (rand_items < 300) begin
      hw = $urandom_range(0, 7);
      hh = $urandom_range(0, 7);
      w = $urandom_range(1, 16);
      h = $urandom_range(1, 12);
      frames = $urandom_range(1, 2);
      setup(hw, hh, w, h);
      if (phase == 2) long_hold = 1;
      for (int f = 0; f < frames; f++)
        for (int p = 0; p < w * h; p++) begin
          if ($urandom_range(0, 9) == 0)
            push_item(KIND_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
          push_pixel();
          rand_items++;
        end
      drain_backlog();
      settle();
      phase++;
      if (rand_items > 230) quiet = 1;
    end

    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.means_due.size() == 0)
      $display("tb_box_average_filter_top: done, clean");
    else
      $display("tb_box_average_filter_top: done, errors");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/baf_pkg.sv
rtl/baf_div.sv
rtl/baf_dp.sv
rtl/baf_ctrl.sv
rtl/box_average_filter_top.sv
tb/sv/tb_box_average_filter_top.sv
